@@ hdl/bfa_pkg.sv @@
// Shared types and constants of the best-fit boundary-tag allocator.
// Command and register codes, sequencer states and the result record.
// No dependencies.
`default_nettype none
package bfa_pkg;

    localparam int unsigned HEAP_BYTES_DEF = 4096;
    localparam int unsigned TAG_BYTES_DEF  = 4;

    localparam int unsigned CFG_HEAP_W = 13;
    localparam int unsigned CFG_MINB_W = 9;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned SIZE_W     = 13;
    localparam int unsigned ALOG_W     = 3;
    localparam int unsigned ADDR_W     = 12;

    localparam logic [CFG_HEAP_W-1:0] HEAP_CFG_RST = 13'd4096;
    localparam logic [CFG_MINB_W-1:0] MINB_CFG_RST = 9'd16;

    typedef enum logic [1:0] {
        CMD_INIT     = 2'd0,
        CMD_ALLOC    = 2'd1,
        CMD_FREE     = 2'd2,
        CMD_CONTAINS = 2'd3
    } cmd_t;

    typedef enum logic {
        CFG_HEAP_BYTES = 1'b0,
        CFG_MIN_BLOCK  = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDT,
        ST_WRT,
        ST_WRB,
        ST_WRB2,
        ST_INIT,
        ST_INIT1,
        ST_INIT2,
        ST_A_START,
        ST_A_CHK,
        ST_A_EVAL,
        ST_A_DEC,
        ST_A_SPL2,
        ST_A_SPL3,
        ST_A_OFF,
        ST_A_OFF2,
        ST_A_RES,
        ST_F_START,
        ST_F_OFF,
        ST_F_CS,
        ST_F_PS0,
        ST_F_PS,
        ST_F_PT,
        ST_F_NX,
        ST_F_NT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              status;
        logic [ADDR_W-1:0] payload_address;
        logic              in_heap;
    } res_t;

endpackage
`default_nettype wire

@@ hdl/bfa_mem.sv @@
// Byte-wide heap store with one port and a registered read.
// Standalone; no package needed.
`default_nettype none
module bfa_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

@@ hdl/bfa_seq.sv @@
// Sequencer of the allocator: clearing pass, init, best-fit walk, free and merge, contains query.
// Reads and writes tags byte by byte through bfa_mem; uses bfa_pkg.
`default_nettype none
module bfa_seq #(
    parameter int unsigned HEAP_BYTES = 4096,
    parameter int unsigned TAG_BYTES  = 4,
    parameter int unsigned AW         = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire bfa_pkg::cmd_t                   req_cmd,
    input  wire logic [bfa_pkg::SIZE_W-1:0]      req_size,
    input  wire logic [bfa_pkg::ALOG_W-1:0]      req_alog,
    input  wire logic [bfa_pkg::ADDR_W-1:0]      req_addr,
    input  wire logic [bfa_pkg::CFG_HEAP_W-1:0]  heap_cfg,
    input  wire logic [bfa_pkg::CFG_MINB_W-1:0]  minb_cfg,
    output bfa_pkg::res_t                        res,
    input  wire logic                            res_ready,
    output logic                                 mem_we,
    output logic [AW-1:0]                        mem_addr,
    output logic [7:0]                           mem_wdata,
    input  wire logic [7:0]                      mem_rdata
);
    import bfa_pkg::*;

    localparam int unsigned PW = $clog2(HEAP_BYTES) + 1;
    localparam int unsigned SW = ((PW > SIZE_W) ? PW : SIZE_W) + 2;
    localparam int unsigned TW = 8 * TAG_BYTES;
    localparam int unsigned CW = $clog2(TAG_BYTES + 1);
    localparam logic [SW-1:0] TB   = SW'(TAG_BYTES);
    localparam logic [SW-1:0] TB2  = SW'(2 * TAG_BYTES);
    localparam logic [SW-1:0] TB4  = SW'(4 * TAG_BYTES);
    localparam logic [SW-1:0] HMAX = SW'(HEAP_BYTES);

    function automatic logic [SW-1:0] tag_size(input logic [TW-1:0] t);
        logic [TW-1:0] s;
        s = t >> 1;
        if ((s >> SW) != '0)
        begin
            return '1;
        end
        return SW'(s);
    endfunction

    state_t          state_reg, state_next, ret_reg, ret_next, bret_reg, bret_next;
    cmd_t            cmd_reg, cmd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            boot_reg, boot_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ALOG_W-1:0] alog_reg, alog_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SW-1:0]   active_reg, active_next;
    logic [SW-1:0]   pos_reg, pos_next, best_reg, best_next, bsz_reg, bsz_next;
    logic            found_reg, found_next;
    logic [SW-1:0]   req_reg, req_next, align_reg, align_next;
    logic [TW-1:0]   tag_reg, tag_next, wval_reg, wval_next;
    logic [SW-1:0]   rpos_reg, rpos_next, wpos_reg, wpos_next, wsize_reg, wsize_next;
    logic            wfree_reg, wfree_next;
    logic [SW-1:0]   cur_reg, cur_next, cs_reg, cs_next, prev_reg, prev_next, a_reg, a_next;
    logic            status_reg, status_next, inh_reg, inh_next;
    logic [ADDR_W-1:0] pay_reg, pay_next;

    logic [SW-1:0] endp, mb, s, off, p, h, rq;
    logic [SW:0]   ns;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ret_reg   <= ST_IDLE;
            bret_reg  <= ST_IDLE;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            boot_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            bret_reg  <= bret_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            boot_reg  <= boot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        size_reg   <= size_next;
        alog_reg   <= alog_next;
        addr_reg   <= addr_next;
        active_reg <= active_next;
        pos_reg    <= pos_next;
        best_reg   <= best_next;
        bsz_reg    <= bsz_next;
        found_reg  <= found_next;
        req_reg    <= req_next;
        align_reg  <= align_next;
        tag_reg    <= tag_next;
        wval_reg   <= wval_next;
        rpos_reg   <= rpos_next;
        wpos_reg   <= wpos_next;
        wsize_reg  <= wsize_next;
        wfree_reg  <= wfree_next;
        cur_reg    <= cur_next;
        cs_reg     <= cs_next;
        prev_reg   <= prev_next;
        a_reg      <= a_next;
        status_reg <= status_next;
        inh_reg    <= inh_next;
        pay_reg    <= pay_next;
    end

    always_comb
    begin
        endp = active_reg - TB;
        mb   = (SW'(minb_cfg) < TB2) ? TB2 : SW'(minb_cfg);
        s    = tag_size(tag_reg);
        p    = best_reg + TB;
        off  = align_reg - (p & (align_reg - SW'(1)));
        h    = SW'(heap_cfg);
        rq   = SW'(size_reg) + align_reg + TB2;
        ns   = '0;

        state_next  = state_reg;
        ret_next    = ret_reg;
        bret_next   = bret_reg;
        cmd_next    = cmd_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        boot_next   = boot_reg;
        size_next   = size_reg;
        alog_next   = alog_reg;
        addr_next   = addr_reg;
        active_next = active_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        bsz_next    = bsz_reg;
        found_next  = found_reg;
        req_next    = req_reg;
        align_next  = align_reg;
        tag_next    = tag_reg;
        wval_next   = wval_reg;
        rpos_next   = rpos_reg;
        wpos_next   = wpos_reg;
        wsize_next  = wsize_reg;
        wfree_next  = wfree_reg;
        cur_next    = cur_reg;
        cs_next     = cs_reg;
        prev_next   = prev_reg;
        a_next      = a_reg;
        status_next = status_reg;
        inh_next    = inh_reg;
        pay_next    = pay_reg;

        req_ready = 1'b0;
        res       = '0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                if (clr_reg == AW'(HEAP_BYTES - 1))
                begin
                    state_next = ST_INIT;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next    = req_cmd;
                    size_next   = req_size;
                    alog_next   = req_alog;
                    addr_next   = req_addr;
                    status_next = 1'b0;
                    inh_next    = 1'b0;
                    pay_next    = '0;
                    case (req_cmd)
                        CMD_INIT:  state_next = ST_INIT;
                        CMD_ALLOC: state_next = ST_A_START;
                        CMD_FREE:  state_next = ST_F_START;
                        default:
                        begin
                            inh_next   = (SW'(req_addr) < active_reg);
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RDT:
            begin
                if (cnt_reg < CW'(TAG_BYTES))
                begin
                    mem_addr = AW'(rpos_reg + SW'(cnt_reg));
                end
                if (cnt_reg != '0)
                begin
                    tag_next[8 * int'(CW'(cnt_reg - CW'(1))) +: 8] = mem_rdata;
                end
                if (cnt_reg == CW'(TAG_BYTES))
                begin
                    cnt_next   = '0;
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_WRT:
            begin
                mem_we    = 1'b1;
                mem_addr  = AW'(wpos_reg + SW'(cnt_reg));
                mem_wdata = wval_reg[8 * int'(cnt_reg) +: 8];
                if (cnt_reg == CW'(TAG_BYTES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_WRB:
            begin
                wval_next  = TW'({wsize_reg, wfree_reg});
                cnt_next   = '0;
                ret_next   = ST_WRB2;
                state_next = ST_WRT;
            end
            ST_WRB2:
            begin
                wpos_next  = wpos_reg + wsize_reg - TB;
                cnt_next   = '0;
                ret_next   = bret_reg;
                state_next = ST_WRT;
            end
            ST_INIT:
            begin
                if (h < TB4)
                begin
                    active_next = TB4;
                end
                else if (h > HMAX)
                begin
                    active_next = HMAX;
                end
                else
                begin
                    active_next = h;
                end
                wpos_next  = '0;
                wval_next  = TW'(2 * TAG_BYTES);
                cnt_next   = '0;
                ret_next   = ST_INIT1;
                state_next = ST_WRT;
            end
            ST_INIT1:
            begin
                wpos_next  = active_reg - TB;
                cnt_next   = '0;
                ret_next   = ST_INIT2;
                state_next = ST_WRT;
            end
            ST_INIT2:
            begin
                wpos_next  = TB;
                wsize_next = active_reg - TB2;
                wfree_next = 1'b1;
                bret_next  = ST_DONE;
                state_next = ST_WRB;
            end
            ST_A_START:
            begin
                align_next = SW'(1) << alog_reg;
                pos_next   = TB;
                found_next = 1'b0;
                state_next = ST_A_CHK;
            end
            ST_A_CHK:
            begin
                if (pos_reg == TB)
                begin
                    req_next = (rq < mb) ? mb : rq;
                end
                if (pos_reg < endp)
                begin
                    rpos_next  = pos_reg;
                    cnt_next   = '0;
                    ret_next   = ST_A_EVAL;
                    state_next = ST_RDT;
                end
                else
                begin
                    state_next = ST_A_DEC;
                end
            end
            ST_A_EVAL:
            begin
                if (s == '0 || s > endp - pos_reg)
                begin
                    state_next = ST_A_DEC;
                end
                else
                begin
                    if (tag_reg[0] && s >= req_reg && (!found_reg || s < bsz_reg))
                    begin
                        found_next = 1'b1;
                        best_next  = pos_reg;
                        bsz_next   = s;
                    end
                    pos_next   = pos_reg + s;
                    state_next = ST_A_CHK;
                end
            end
            ST_A_DEC:
            begin
                if (!found_reg)
                begin
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (bsz_reg - req_reg >= mb)
                begin
                    wpos_next  = best_reg;
                    wsize_next = req_reg;
                    wfree_next = 1'b1;
                    bret_next  = ST_A_SPL2;
                    state_next = ST_WRB;
                end
                else
                begin
                    state_next = ST_A_OFF;
                end
            end
            ST_A_SPL2:
            begin
                wpos_next  = best_reg + req_reg;
                wsize_next = bsz_reg - req_reg;
                wfree_next = 1'b1;
                bret_next  = ST_A_SPL3;
                state_next = ST_WRB;
            end
            ST_A_SPL3:
            begin
                bsz_next   = req_reg;
                state_next = ST_A_OFF;
            end
            ST_A_OFF:
            begin
                mem_we     = 1'b1;
                mem_addr   = AW'(p);
                mem_wdata  = 8'(off);
                a_next     = p + off;
                state_next = ST_A_OFF2;
            end
            ST_A_OFF2:
            begin
                mem_we     = 1'b1;
                mem_addr   = AW'(a_reg - SW'(1));
                mem_wdata  = 8'(off);
                wpos_next  = best_reg;
                wsize_next = bsz_reg;
                wfree_next = 1'b0;
                bret_next  = ST_A_RES;
                state_next = ST_WRB;
            end
            ST_A_RES:
            begin
                pay_next   = ADDR_W'(a_reg);
                state_next = ST_DONE;
            end
            ST_F_START:
            begin
                if (addr_reg == '0 || SW'(addr_reg) >= active_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_addr   = AW'(SW'(addr_reg) - SW'(1));
                    state_next = ST_F_OFF;
                end
            end
            ST_F_OFF:
            begin
                cur_next = SW'(addr_reg) - SW'(mem_rdata) - TB;
                if (SW'(mem_rdata) + TB > SW'(addr_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rpos_next  = cur_next;
                    cnt_next   = '0;
                    ret_next   = ST_F_CS;
                    state_next = (cur_next < TB || cur_next >= endp) ? ST_DONE : ST_RDT;
                end
            end
            ST_F_CS:
            begin
                if (s < TB2 || s > endp - cur_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cs_next    = s;
                    wpos_next  = cur_reg;
                    wsize_next = s;
                    wfree_next = 1'b1;
                    bret_next  = ST_F_PS0;
                    state_next = ST_WRB;
                end
            end
            ST_F_PS0:
            begin
                rpos_next  = cur_reg - TB;
                cnt_next   = '0;
                ret_next   = ST_F_PS;
                state_next = ST_RDT;
            end
            ST_F_PS:
            begin
                if (s != '0 && s <= cur_reg)
                begin
                    prev_next  = cur_reg - s;
                    rpos_next  = cur_reg - s;
                    cnt_next   = '0;
                    ret_next   = ST_F_PT;
                    state_next = ST_RDT;
                end
                else
                begin
                    state_next = ST_F_NX;
                end
            end
            ST_F_PT:
            begin
                ns = {1'b0, s} + {1'b0, cs_reg};
                state_next = ST_F_NX;
                if (tag_reg[0] && prev_reg < endp && ns <= {1'b0, endp - prev_reg})
                begin
                    cur_next   = prev_reg;
                    cs_next    = SW'(ns);
                    wpos_next  = prev_reg;
                    wsize_next = SW'(ns);
                    wfree_next = 1'b1;
                    bret_next  = ST_F_NX;
                    state_next = ST_WRB;
                end
            end
            ST_F_NX:
            begin
                if (cur_reg + cs_reg < endp)
                begin
                    rpos_next  = cur_reg + cs_reg;
                    cnt_next   = '0;
                    ret_next   = ST_F_NT;
                    state_next = ST_RDT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_F_NT:
            begin
                ns = {1'b0, s} + {1'b0, cs_reg};
                state_next = ST_DONE;
                if (tag_reg[0] && ns <= {1'b0, endp - cur_reg})
                begin
                    wpos_next  = cur_reg;
                    wsize_next = SW'(ns);
                    wfree_next = 1'b1;
                    bret_next  = ST_DONE;
                    state_next = ST_WRB;
                end
            end
            ST_DONE:
            begin
                if (boot_reg)
                begin
                    boot_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    res.valid           = 1'b1;
                    res.status          = status_reg;
                    res.payload_address = pay_reg;
                    res.in_heap         = inh_reg;
                    if (res_ready)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.in_heap) |-> (cmd_reg == CMD_CONTAINS))
        else $error("in_heap set on a request that is not a query");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status) |-> (cmd_reg == CMD_ALLOC && !found_reg))
        else $error("out-of-memory reported while a block was found");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!boot_reg && state_reg == ST_IDLE) |-> (active_reg >= TB4 && active_reg <= HMAX))
        else $error("active heap size out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_OFF) |-> (found_reg && bsz_reg >= req_reg))
        else $error("alignment write without a fitting block");

endmodule
`default_nettype wire

@@ hdl/best_fit_boundary_tag_allocator.sv @@
// Top level of the best-fit boundary-tag allocator: ports, configuration
// registers and the output register. Uses bfa_pkg, bfa_seq and bfa_mem.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    s_tuser command, s_tdata request
//  m_*       out        m_tvalid/m_tready    m_tdata result
//  cfg_*     in         cfg_write_en         cfg_index, cfg_data
//
// Allocate walks every block of the heap, then decides, splits and tags the
// best one. Tags pass byte by byte through the byte-wide port of the heap
// memory. After reset a clearing pass over all HEAP_BYTES bytes and an init
// run before the first request is taken.
// A waiting result sits in the output register while the next request is
// already taken; a second result holds the sequencer and s_tready low.
`default_nettype none
module best_fit_boundary_tag_allocator #(
    parameter int unsigned HEAP_BYTES = bfa_pkg::HEAP_BYTES_DEF,
    parameter int unsigned TAG_BYTES  = bfa_pkg::TAG_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // request_size[12:0], align_log2[15:13], address[27:16], zero[31:28]
    input  wire logic [31:0]                      s_tdata,
    // command[1:0]
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status[0], payload_address[12:1], in_heap[13], zero[15:14]
    output logic [15:0]                           m_tdata,
    input  wire logic                             cfg_write_en,
    input  wire logic                             cfg_index,
    input  wire logic [bfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bfa_pkg::*;

    localparam int unsigned AW = $clog2(HEAP_BYTES);

    logic [CFG_HEAP_W-1:0] heap_cfg_reg;
    logic [CFG_MINB_W-1:0] minb_cfg_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [15:0]           out_data_reg, out_data_next;
    res_t                  res;
    logic                  res_ready;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [7:0]            mem_wdata, mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_cfg_reg <= HEAP_CFG_RST;
            minb_cfg_reg <= MINB_CFG_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HEAP_BYTES: heap_cfg_reg <= cfg_data[CFG_HEAP_W-1:0];
                CFG_MIN_BLOCK:  minb_cfg_reg <= cfg_data[CFG_MINB_W-1:0];
                default:        heap_cfg_reg <= heap_cfg_reg;
            endcase
        end
    end

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, res.in_heap, res.payload_address, res.status};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    bfa_seq #(
        .HEAP_BYTES (HEAP_BYTES),
        .TAG_BYTES  (TAG_BYTES),
        .AW         (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_cmd   (cmd_t'(s_tuser)),
        .req_size  (s_tdata[12:0]),
        .req_alog  (s_tdata[15:13]),
        .req_addr  (s_tdata[27:16]),
        .heap_cfg  (heap_cfg_reg),
        .minb_cfg  (minb_cfg_reg),
        .res       (res),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    bfa_mem #(
        .DEPTH (HEAP_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire
